@@ rtl/region_profiler_collator_top_assert.svh @@
// Assertion macros shared by the profiler checker.
`ifndef REGION_PROFILER_COLLATOR_TOP_ASSERT_SVH
`define REGION_PROFILER_COLLATOR_TOP_ASSERT_SVH
// Check that an implication holds on every clock edge outside reset.
`define RPC_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Check that an implication holds in the cycle after its trigger.
`define RPC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

@@ rtl/rpc_pkg.sv @@
// Shared types and codes for the region profiler collator.
`timescale 1ns / 1ps
package rpc_pkg;
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] REC_SUMMARY = 2'd0;
    localparam logic [1:0] REC_REGION  = 2'd1;
    localparam logic [1:0] REC_ERROR   = 2'd2;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd0;
    localparam logic [1:0] ERR_TABLE_FULL = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] region_key;
        logic [63:0] timestamp;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [63:0] frame_number;
        logic [31:0] region_key_out;
        logic [31:0] call_count;
        logic [63:0] total_cycles;
        logic [1:0]  error_code;
        logic        last;
    } out_word_t;

    // Classified command handed from front to back.
    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_ERROR = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [1:0]  err;
        logic [31:0] key;
        logic [63:0] start;
        logic [63:0] stamp;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_PROBE = 3'd1,
        BK_READ  = 3'd2,
        BK_WRITE = 3'd3,
        BK_EMIT  = 3'd4,
        BK_DUMP  = 3'd5,
        BK_DUMPW = 3'd6,
        BK_CLEAR = 3'd7
    } bk_state_t;
endpackage

@@ rtl/rpc_front.sv @@
// Front end: open-region stack, classifies events into back-end commands.
`timescale 1ns / 1ps
module rpc_front #(
    parameter int OPEN_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rpc_pkg::in_word_t in_word,
    output logic             cmd_valid,
    input  logic             cmd_stall,
    output rpc_pkg::cmd_t    cmd
);
    import rpc_pkg::*;
    localparam int AW = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
    localparam int DW = $clog2(OPEN_DEPTH + 1);

    logic [31:0] keys_mem [OPEN_DEPTH];
    logic [63:0] starts_mem [OPEN_DEPTH];
    logic [DW-1:0] depth_reg, depth_next;
    // Pop needs a registered read: pop_reg stalls the input while the popped entry is read.
    logic pop_reg, pop_next;
    in_word_t hold_reg;
    logic [31:0] rd_key_reg;
    logic [63:0] rd_start_reg;
    logic cvalid_reg, cvalid_next;
    cmd_t cmd_reg, cmd_next;
    logic [AW-1:0] top_idx;
    logic take;

    assign top_idx = AW'(depth_reg - DW'(1));
    assign in_stall = pop_reg || (cvalid_reg && cmd_stall);
    assign take = in_valid && !in_stall;
    assign cmd_valid = cvalid_reg;
    assign cmd = cmd_reg;

    always_ff @(posedge clk)
    begin
        if (take && in_word.kind == KIND_BEGIN && depth_reg < DW'(OPEN_DEPTH))
        begin
            keys_mem[AW'(depth_reg)] <= in_word.region_key;
            starts_mem[AW'(depth_reg)] <= in_word.timestamp;
        end
        rd_key_reg <= keys_mem[top_idx];
        rd_start_reg <= starts_mem[top_idx];
        if (take)
            hold_reg <= in_word;
    end

    always_comb
    begin
        depth_next = depth_reg;
        pop_next = 1'b0;
        cvalid_next = cvalid_reg && cmd_stall;
        cmd_next = cmd_reg;
        if (pop_reg)
        begin
            cvalid_next = 1'b1;
            cmd_next.op = CMD_CLOSE;
            cmd_next.err = ERR_UNDERFLOW;
            cmd_next.key = rd_key_reg;
            cmd_next.start = rd_start_reg;
            cmd_next.stamp = hold_reg.timestamp;
        end
        else if (take)
        begin
            cmd_next.key = '0;
            cmd_next.start = '0;
            cmd_next.stamp = in_word.timestamp;
            cmd_next.err = ERR_UNDERFLOW;
            case (in_word.kind)
                KIND_BEGIN:
                begin
                    if (depth_reg < DW'(OPEN_DEPTH))
                        depth_next = depth_reg + DW'(1);
                    else
                    begin
                        cvalid_next = 1'b1;
                        cmd_next.op = CMD_ERROR;
                        cmd_next.err = ERR_OVERFLOW;
                    end
                end
                KIND_END:
                begin
                    if (depth_reg != '0)
                    begin
                        depth_next = depth_reg - DW'(1);
                        pop_next = 1'b1;
                    end
                    else
                    begin
                        cvalid_next = 1'b1;
                        cmd_next.op = CMD_ERROR;
                        cmd_next.err = ERR_UNDERFLOW;
                    end
                end
                KIND_FRAME:
                begin
                    cvalid_next = 1'b1;
                    cmd_next.op = CMD_FRAME;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            pop_reg <= 1'b0;
            cvalid_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            pop_reg <= pop_next;
            cvalid_reg <= cvalid_next;
        end
    end

    always_ff @(posedge clk)
        cmd_reg <= cmd_next;
endmodule

@@ rtl/rpc_queue.sv @@
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module rpc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_stall,
    input  rpc_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_stall,
    output rpc_pkg::cmd_t rd_cmd
);
    import rpc_pkg::*;
    cmd_t buf_reg [2];
    logic wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_cmd = buf_reg[rptr_reg];
    assign push = wr_valid && !wr_stall;
    assign pop = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ rtl/rpc_back.sv @@
// Back end: probed record table, frame dump and result register.
`timescale 1ns / 1ps
module rpc_back #(
    parameter int RECORD_SLOTS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  rpc_pkg::cmd_t     cmd,
    output logic              out_valid,
    input  logic              out_stall,
    output rpc_pkg::out_word_t out_word
);
    import rpc_pkg::*;
    localparam int SW = $clog2(RECORD_SLOTS);
    localparam int TW = $clog2(RECORD_SLOTS + 1);

    logic [31:0] slot_keys [RECORD_SLOTS];
    logic [SW-1:0] slot_idx [RECORD_SLOTS];
    logic [31:0] rec_keys [RECORD_SLOTS];
    logic [31:0] rec_calls [RECORD_SLOTS];
    logic [63:0] rec_cycles [RECORD_SLOTS];
    logic [RECORD_SLOTS-1:0] valid_reg, valid_next;

    bk_state_t state_reg, state_next;
    cmd_t cur_reg, cur_next;
    logic [SW-1:0] probe_reg, probe_next;
    logic [TW-1:0] steps_reg, steps_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] dump_reg, dump_next;
    logic [SW-1:0] rec_reg, rec_next;
    logic new_reg, new_next;
    logic [63:0] fbegin_reg, fbegin_next;
    logic [63:0] fcount_reg, fcount_next;
    logic ovalid_reg, ovalid_next;
    out_word_t out_reg, out_next;

    // Slot read data, registered.
    logic [31:0] sk_rd_reg;
    logic [SW-1:0] si_rd_reg;
    logic [31:0] rk_rd_reg, rc_rd_reg;
    logic [63:0] ry_rd_reg;
    logic [SW-1:0] rd_addr;
    logic slot_we, rec_we;
    logic [31:0] wr_calls;
    logic [63:0] wr_cycles;
    logic out_free;

    assign out_free = !ovalid_reg || !out_stall;
    assign cmd_stall = (state_reg != BK_IDLE);
    assign out_valid = ovalid_reg;
    assign out_word = out_reg;

    always_ff @(posedge clk)
    begin
        sk_rd_reg <= slot_keys[probe_next];
        si_rd_reg <= slot_idx[probe_next];
        rk_rd_reg <= rec_keys[rd_addr];
        rc_rd_reg <= rec_calls[rd_addr];
        ry_rd_reg <= rec_cycles[rd_addr];
        if (slot_we)
        begin
            slot_keys[probe_reg] <= cur_reg.key;
            slot_idx[probe_reg] <= SW'(total_reg);
        end
        if (rec_we)
        begin
            rec_keys[rec_reg] <= cur_reg.key;
            rec_calls[rec_reg] <= wr_calls;
            rec_cycles[rec_reg] <= wr_cycles;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        probe_next = probe_reg;
        steps_next = steps_reg;
        total_next = total_reg;
        dump_next = dump_reg;
        rec_next = rec_reg;
        new_next = new_reg;
        fbegin_next = fbegin_reg;
        fcount_next = fcount_reg;
        valid_next = valid_reg;
        ovalid_next = ovalid_reg && out_stall;
        out_next = out_reg;
        rd_addr = rec_reg;
        slot_we = 1'b0;
        rec_we = 1'b0;
        wr_calls = (new_reg ? 32'd0 : rc_rd_reg);
        if (wr_calls != 32'hFFFF_FFFF)
            wr_calls = wr_calls + 32'd1;
        wr_cycles = (new_reg ? 64'd0 : ry_rd_reg) + (cur_reg.stamp - cur_reg.start);
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    case (cmd.op)
                        CMD_CLOSE:
                        begin
                            probe_next = cmd.key[SW-1:0];
                            steps_next = '0;
                            state_next = BK_PROBE;
                        end
                        CMD_FRAME:
                        begin
                            dump_next = '0;
                            state_next = BK_EMIT;
                        end
                        default: state_next = BK_EMIT;
                    endcase
                end
            end
            BK_PROBE:
            begin
                // Slot data for probe_reg is now registered.
                if (!valid_reg[probe_reg])
                begin
                    if (total_reg >= TW'(RECORD_SLOTS))
                    begin
                        cur_next.op = CMD_ERROR;
                        cur_next.err = ERR_TABLE_FULL;
                        state_next = BK_EMIT;
                    end
                    else
                    begin
                        slot_we = 1'b1;
                        valid_next[probe_reg] = 1'b1;
                        rec_next = SW'(total_reg);
                        total_next = total_reg + TW'(1);
                        new_next = 1'b1;
                        state_next = BK_WRITE;
                    end
                end
                else if (sk_rd_reg == cur_reg.key)
                begin
                    rec_next = si_rd_reg;
                    new_next = 1'b0;
                    state_next = BK_READ;
                end
                else if (steps_reg == TW'(RECORD_SLOTS - 1))
                begin
                    cur_next.op = CMD_ERROR;
                    cur_next.err = ERR_TABLE_FULL;
                    state_next = BK_EMIT;
                end
                else
                begin
                    probe_next = probe_reg + SW'(1);
                    steps_next = steps_reg + TW'(1);
                end
            end
            BK_READ:
            begin
                rd_addr = rec_reg;
                state_next = BK_WRITE;
            end
            BK_WRITE:
            begin
                rec_we = 1'b1;
                state_next = BK_IDLE;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    out_next.frame_number = fcount_reg;
                    out_next.region_key_out = '0;
                    out_next.error_code = 2'd0;
                    if (cur_reg.op == CMD_FRAME)
                    begin
                        out_next.record_kind = REC_SUMMARY;
                        out_next.call_count = 32'(total_reg);
                        out_next.total_cycles = cur_reg.stamp - fbegin_reg;
                        out_next.last = (total_reg == '0);
                        rd_addr = '0;
                        state_next = (total_reg == '0) ? BK_CLEAR : BK_DUMPW;
                    end
                    else
                    begin
                        out_next.record_kind = REC_ERROR;
                        out_next.call_count = '0;
                        out_next.total_cycles = '0;
                        out_next.error_code = cur_reg.err;
                        out_next.last = 1'b1;
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_DUMPW:
            begin
                // Record read for dump_reg is now registered.
                rd_addr = SW'(dump_reg);
                state_next = BK_DUMP;
            end
            BK_DUMP:
            begin
                rd_addr = SW'(dump_reg);
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    out_next.record_kind = REC_REGION;
                    out_next.frame_number = fcount_reg;
                    out_next.region_key_out = rk_rd_reg;
                    out_next.call_count = rc_rd_reg;
                    out_next.total_cycles = ry_rd_reg;
                    out_next.error_code = 2'd0;
                    out_next.last = (dump_reg + TW'(1) == total_reg);
                    dump_next = dump_reg + TW'(1);
                    if (dump_reg + TW'(1) == total_reg)
                        state_next = BK_CLEAR;
                    else
                    begin
                        rd_addr = SW'(dump_reg + TW'(1));
                        state_next = BK_DUMPW;
                    end
                end
            end
            BK_CLEAR:
            begin
                valid_next = '0;
                total_next = '0;
                fcount_next = fcount_reg + 64'd1;
                fbegin_next = cur_reg.stamp;
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= '0;
            total_reg <= '0;
            fbegin_reg <= '0;
            fcount_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            total_reg <= total_next;
            fbegin_reg <= fbegin_next;
            fcount_reg <= fcount_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        probe_reg <= probe_next;
        steps_reg <= steps_next;
        dump_reg <= dump_next;
        rec_reg <= rec_next;
        new_reg <= new_next;
        out_reg <= out_next;
    end
endmodule

@@ rtl/region_profiler_collator_top.sv @@
// Region profiler collator: an end event pops the open-region stack in the front (a registered
// stack read), then the back takes the command, probes slots in turn, and either reads and
// rewrites an existing record or writes a new one; begin events only push the stack and need
// the back only when the stack overflows. A frame marker streams a summary and then each
// record out of the record memory, then clears the table.
// A two-entry queue parts the stack front from the table back.
`timescale 1ns / 1ps
module region_profiler_collator_top #(
    parameter int RECORD_SLOTS = 32,
    parameter int OPEN_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rpc_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output rpc_pkg::out_word_t out_word
);
    import rpc_pkg::*;
    cmd_t f_cmd, q_cmd;
    logic f_valid, f_stall, q_valid, q_stall;

    rpc_front #(.OPEN_DEPTH(OPEN_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_word(in_word), .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
    );
    rpc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(f_stall),
        .wr_cmd(f_cmd), .rd_valid(q_valid), .rd_stall(q_stall), .rd_cmd(q_cmd)
    );
    rpc_back #(.RECORD_SLOTS(RECORD_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_stall(q_stall),
        .cmd(q_cmd), .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );
endmodule

@@ rtl/rpc_checker.sv @@
// Port checker for the profiler collator and its bind.
`timescale 1ns / 1ps
`include "region_profiler_collator_top_assert.svh"
module rpc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input rpc_pkg::out_word_t out_word
);
    import rpc_pkg::*;
    `RPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))
    `RPC_ASSERT_IMPL(a_err_last, clk, rst_n, out_valid && out_word.record_kind == REC_ERROR, out_word.last)
    `RPC_ASSERT_IMPL(a_kind_ok, clk, rst_n, out_valid, out_word.record_kind != 2'd3)
    `RPC_ASSERT_IMPL(a_sum_key, clk, rst_n, out_valid && out_word.record_kind == REC_SUMMARY, out_word.region_key_out == 32'd0)
endmodule

bind region_profiler_collator_top rpc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
);

@@ tb/region_profiler_collator_top_test.sv @@
// Self-checking testbench for the region profiler collator: predicts frame records and errors.
`timescale 1ns / 1ps
module region_profiler_collator_top_test;
    import rpc_pkg::*;

    localparam int SLOTS = 32;
    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;

    region_profiler_collator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // predictor state
    logic [31:0] stk_key [DEPTH];
    logic [63:0] stk_start [DEPTH];
    int          stk_depth;
    logic [31:0] slot_key [SLOTS];
    bit          slot_used [SLOTS];
    int          slot_rec [SLOTS];
    logic [31:0] rec_key [SLOTS];
    logic [31:0] rec_calls [SLOTS];
    logic [63:0] rec_cycles [SLOTS];
    int          rec_total;
    logic [63:0] frame_start;
    logic [63:0] frame_no;

    out_word_t pending_q [$];
    int        errors;
    int        mismatches;
    longint    cycles;
    logic [63:0] now_ts;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic out_word_t make_word(logic [1:0] rk, logic [31:0] key, logic [31:0] calls,
                                            logic [63:0] cyc, logic [1:0] err, logic lst);
        out_word_t w;
        w.record_kind = rk;
        w.frame_number = frame_no;
        w.region_key_out = key;
        w.call_count = calls;
        w.total_cycles = cyc;
        w.error_code = err;
        w.last = lst;
        return w;
    endfunction

    function automatic in_word_t rand_word();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(in_word_t)-1:0];
    endfunction

    task automatic predict_event(input in_word_t w);
        int          idx;
        int          rec;
        bit          found;
        logic [31:0] key;
        logic [63:0] start;
        if (w.kind == KIND_BEGIN)
        begin
            if (stk_depth >= DEPTH)
                pending_q.push_back(make_word(REC_ERROR, 0, 0, 0, ERR_OVERFLOW, 1'b1));
            else
            begin
                stk_key[stk_depth] = w.region_key;
                stk_start[stk_depth] = w.timestamp;
                stk_depth++;
            end
        end
        else if (w.kind == KIND_END)
        begin
            if (stk_depth == 0)
            begin
                pending_q.push_back(make_word(REC_ERROR, 0, 0, 0, ERR_UNDERFLOW, 1'b1));
                return;
            end
            stk_depth--;
            key = stk_key[stk_depth];
            start = stk_start[stk_depth];
            found = 0;
            rec = 0;
            for (int off = 0; off < SLOTS; off++)
            begin
                idx = (key % SLOTS + off) % SLOTS;
                if (!slot_used[idx])
                begin
                    if (rec_total >= SLOTS)
                        break;
                    slot_used[idx] = 1;
                    slot_key[idx] = key;
                    rec = rec_total++;
                    slot_rec[idx] = rec;
                    rec_key[rec] = key;
                    rec_calls[rec] = 0;
                    rec_cycles[rec] = 0;
                    found = 1;
                    break;
                end
                if (slot_key[idx] == key)
                begin
                    rec = slot_rec[idx];
                    found = 1;
                    break;
                end
            end
            if (!found)
            begin
                pending_q.push_back(make_word(REC_ERROR, 0, 0, 0, ERR_TABLE_FULL, 1'b1));
                return;
            end
            if (rec_calls[rec] != 32'hFFFF_FFFF)
                rec_calls[rec]++;
            rec_cycles[rec] += w.timestamp - start;
        end
        else if (w.kind == KIND_FRAME)
        begin
            pending_q.push_back(make_word(REC_SUMMARY, 0, rec_total, w.timestamp - frame_start,
                                          0, rec_total == 0));
            for (int i = 0; i < rec_total; i++)
                pending_q.push_back(make_word(REC_REGION, rec_key[i], rec_calls[i], rec_cycles[i],
                                              0, i + 1 == rec_total));
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 0;
            rec_total = 0;
            frame_no++;
            frame_start = w.timestamp;
        end
    endtask

    // send one word with a random lead-in gap; hold valid after the accept so that
    // a word with no gap follows back to back
    task automatic send_word(input logic [1:0] kind, input logic [31:0] key,
                             input logic [63:0] ts);
        in_word_t w;
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            in_word <= rand_word();
            repeat (gap) @(negedge clk);
        end
        w.kind = kind;
        w.region_key = key;
        w.timestamp = ts;
        in_word <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_event(w);
        @(negedge clk);
    endtask

    function automatic logic [63:0] tick(input int lo, input int hi);
        now_ts += $urandom_range(lo, hi);
        return now_ts;
    endfunction

    task automatic drain_results();
        in_valid <= 1'b0;
        in_word <= rand_word();
        while (pending_q.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // random stall on the result side, with quiet stretches
    int stall_left;
    int quiet_left;
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (quiet_left > 0)
        begin
            quiet_left--;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 19) == 0)
                quiet_left = $urandom_range(20, 80);
            else
                stall_left = $urandom_range(0, 9);
        end
    end

    always @(posedge clk)
    begin
        out_word_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result word %h", out_word);
            end
            else
            begin
                exp = pending_q.pop_front();
                if (out_word !== exp)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: kind %0d/%0d frame %0d/%0d key %h/%h calls %0d/%0d cyc %0d/%0d err %0d/%0d last %0d/%0d",
                                 exp.record_kind, out_word.record_kind,
                                 exp.frame_number, out_word.frame_number,
                                 exp.region_key_out, out_word.region_key_out,
                                 exp.call_count, out_word.call_count,
                                 exp.total_cycles, out_word.total_cycles,
                                 exp.error_code, out_word.error_code,
                                 exp.last, out_word.last);
                end
            end
        end
    end

    task automatic test_field_extremes();
        send_word(KIND_FRAME, 32'h0, 64'h0);
        send_word(KIND_BEGIN, 32'h0, 64'h0);
        send_word(KIND_BEGIN, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
        send_word(KIND_END, 32'hFFFF_FFFF, 64'h5);
        send_word(KIND_END, 32'hA5A5_A5A5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(2'd3, 32'h1234_5678, 64'h77);
        send_word(KIND_FRAME, 32'hFFFF_FFFF, 64'h10);
        send_word(KIND_FRAME, 32'h0, 64'h8);
        now_ts = 64'h100;
    endtask

    task automatic test_underflow_and_overflow();
        send_word(KIND_END, 32'h1, tick(1, 5));
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(KIND_BEGIN, i * SLOTS + 3, tick(1, 5));
        for (int i = 0; i < DEPTH + 1; i++)
            send_word(KIND_END, 0, tick(1, 9));
        send_word(KIND_FRAME, 0, tick(1, 5));
    endtask

    task automatic test_table_full();
        // distinct keys, colliding homes, plus one open region across the marker
        send_word(KIND_BEGIN, 32'hBEEF, tick(1, 3));
        for (int i = 0; i < SLOTS + 2; i++)
        begin
            send_word(KIND_BEGIN, (i % 3 == 0) ? i * SLOTS : i + 7, tick(1, 3));
            send_word(KIND_END, 0, tick(1, 30));
        end
        send_word(KIND_FRAME, 0, tick(1, 5));
        send_word(KIND_END, 0, tick(1, 5));
        send_word(KIND_FRAME, 0, tick(1, 5));
    endtask

    task automatic test_random_frames(input int items);
        int sent;
        int choice;
        sent = 0;
        while (sent < items)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 3)
            begin
                send_word(2'd3, $urandom, {$urandom, $urandom});
                continue;
            end
            if (choice < 10)
                send_word(KIND_FRAME, $urandom, ($urandom_range(0, 3) == 0) ?
                          {$urandom, $urandom} : tick(1, 50));
            else if (choice < 55 || stk_depth == 0 && choice < 90)
                send_word(KIND_BEGIN, ($urandom_range(0, 4) == 0) ? $urandom
                          : $urandom_range(0, 40), ($urandom_range(0, 9) == 0) ?
                          {$urandom, $urandom} : tick(0, 100));
            else
                send_word(KIND_END, $urandom, ($urandom_range(0, 9) == 0) ?
                          {$urandom, $urandom} : tick(0, 100));
            sent++;
            if (sent == items / 2)
                drain_results();
        end
        send_word(KIND_FRAME, 0, tick(1, 5));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        stk_depth = 0;
        rec_total = 0;
        frame_start = 0;
        frame_no = 0;
        now_ts = 0;
        for (int i = 0; i < SLOTS; i++)
            slot_used[i] = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_field_extremes();
        test_underflow_and_overflow();
        test_table_full();
        test_random_frames(180);
        drain_results();
        if (errors == 0 && pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rpc_pkg.sv
rtl/rpc_front.sv
rtl/rpc_queue.sv
rtl/rpc_back.sv
rtl/region_profiler_collator_top.sv
rtl/rpc_checker.sv
tb/region_profiler_collator_top_test.sv
